// ===== rtl/gf2_matrix_rank_unit_assert.svh =====
// Assertion macros for the checker file of the rank unit.
`ifndef GF2_MATRIX_RANK_UNIT_ASSERT_SVH
`define GF2_MATRIX_RANK_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define GF2R_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define GF2R_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gf2r_pkg.sv =====
package gf2r_pkg;

    // Fixed field widths
    localparam int ROW_W      = 32;
    localparam int RANK_W     = 6;
    localparam int OUT_DATA_W = 8;

    // Basis slots available (one per column of the row field)
    localparam int SLOT_COUNT = 32;

    // Default column count
    localparam int ROW_BITS_DEF = 32;

    // Result handed from the elimination core to the output stage
    typedef struct packed {
        logic              valid;
        logic [RANK_W-1:0] rank;
    } t_res;

endpackage

// ===== rtl/gf2_matrix_rank_unit.sv =====
// GF(2) matrix rank unit.
// Rows stream in on the s-side channel, one row per transaction: tdata carries
// the row (bit c is column c), tlast marks the final row of a matrix. Bits at
// or above ROW_BITS are ignored; at most 32 columns are used.
// Each row is reduced against a basis held in a small synchronous RAM, one
// column a cycle from the highest down, with the next slot prefetched. The
// scan of a row ends when it reduces to zero, finds an empty slot or passes
// column zero. s_tready is high only while the unit waits for a row.
// After the row marked last, the rank appears on the m-side channel as the
// low six bits of tdata. When it moves to the output register, the basis is
// cleared (its slot valid bits drop), so the next matrix may follow at once.
// The rank sits in an output register; a stalled receiver does not stop the
// next matrix from being processed, only the next rank from being handed over.
// Reset (synchronous, active low) empties the basis, zeroes the rank count
// and drops m_tvalid.
module gf2_matrix_rank_unit
    import gf2r_pkg::*;
#(
    parameter int ROW_BITS = ROW_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // s-side: tdata = row_bits[31:0]
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [ROW_W-1:0]      i_s_tdata,
    input  logic                  i_s_tlast,
    // m-side: tdata = rank[5:0], zero padding [7:6]
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    localparam int COLS = (ROW_BITS < SLOT_COUNT) ? ROW_BITS : SLOT_COUNT;

    logic              s_accept;
    logic              res_ready;
    t_res              res;
    logic              r_out_valid;
    logic [RANK_W-1:0] r_out_rank;

    assign s_accept  = i_s_tvalid && o_s_tready;
    assign res_ready = !r_out_valid || i_m_tready;

    gf2r_elim #(
        .ROW_BITS (ROW_BITS)
    ) u_elim (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (s_accept),
        .i_row       (i_s_tdata[COLS-1:0]),
        .i_last      (i_s_tlast),
        .o_ready     (o_s_tready),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res.valid;
            if (res.valid) begin
                r_out_rank <= res.rank;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - RANK_W){1'b0}}, r_out_rank};

endmodule

// ===== rtl/gf2r_ram.sv =====
module gf2r_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/gf2r_elim.sv =====
module gf2r_elim
    import gf2r_pkg::*;
#(
    parameter int ROW_BITS = ROW_BITS_DEF,
    localparam int COLS    = (ROW_BITS < SLOT_COUNT) ? ROW_BITS : SLOT_COUNT,
    localparam int AW      = (COLS > 1) ? $clog2(COLS) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,     // row transaction accepted this cycle
    input  logic [COLS-1:0] i_row,
    input  logic            i_last,
    output logic            o_ready,
    input  logic            i_res_ready, // output stage can take a rank
    output t_res            o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    localparam logic [AW-1:0] TOP_COL = AW'(COLS - 1);

    t_state            r_state;
    logic [COLS-1:0]   r_row;
    logic              r_last;
    logic [AW-1:0]     r_col;
    logic [COLS-1:0]   r_valid;
    logic [RANK_W-1:0] r_rank;

    logic [AW-1:0]     rd_addr;
    logic [COLS-1:0]   rd_data;
    logic              cur_bit;
    logic              cur_vld;
    logic              row_zero;
    logic              ins_slot;
    logic [COLS-1:0]   n_row;

    // Basis store: slot c holds a row whose leading bit is c
    gf2r_ram #(
        .WIDTH (COLS),
        .DEPTH (COLS)
    ) u_basis (
        .i_clk   (i_clk),
        .i_we    (ins_slot),
        .i_waddr (r_col),
        .i_wdata (r_row),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Prefetch: the slot for the next column is read during the current column's step
    assign rd_addr  = (r_state == S_IDLE) ? TOP_COL : (r_col - 1'b1);

    assign cur_bit  = r_row[r_col];
    assign cur_vld  = r_valid[r_col];
    assign row_zero = (r_row == '0);
    assign ins_slot = (r_state == S_SCAN) && !row_zero && cur_bit && !cur_vld;
    assign n_row    = cur_bit ? (r_row ^ rd_data) : r_row;

    assign o_ready     = (r_state == S_IDLE);
    assign o_res.valid = (r_state == S_DONE) && r_last;
    assign o_res.rank  = r_rank;

    // Sequencer: scan columns high to low, one reduction step a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_rank  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_row   <= i_row;
                        r_last  <= i_last;
                        r_col   <= TOP_COL;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (row_zero) begin
                        r_state <= S_DONE;
                    end else if (ins_slot) begin
                        r_valid[r_col] <= 1'b1;
                        r_rank         <= r_rank + 1'b1;
                        r_state        <= S_DONE;
                    end else begin
                        r_row <= n_row;
                        if (r_col == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_col <= r_col - 1'b1;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (i_res_ready) begin
                        // rank handed over, start a fresh matrix
                        r_valid <= '0;
                        r_rank  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/gf2r_checker.sv =====
`include "gf2_matrix_rank_unit_assert.svh"

module gf2r_checker
    import gf2r_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata
);

    // A stalled rank holds
    `GF2R_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "rank changed while stalled")

    // The unit is busy in the cycle after taking a row
    `GF2R_ASSERT_NEXT(a_busy_after_row, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready, "row accepted back to back")

    // Rank never exceeds the slot count
    `GF2R_ASSERT_NOW(a_rank_bound, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[RANK_W-1:0] <= RANK_W'(SLOT_COUNT), "rank out of range")

    // Padding bits above the rank stay zero
    `GF2R_ASSERT_NOW(a_pad_zero, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[OUT_DATA_W-1:RANK_W] == '0, "nonzero padding in rank transaction")

endmodule

bind gf2_matrix_rank_unit gf2r_checker u_gf2r_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
